// ----- hw/rtl/pem_pkg.sv -----
// Shared types and constants for the Prewitt edge magnitude block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package pem_pkg;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [12:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;
    localparam logic [12:0] MIN_FRAME_SIZE     = 13'd3;
    localparam logic [12:0] MAX_ROWS           = 13'd4096;
    localparam logic [7:0]  SAT_VALUE          = 8'd255;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // An interior window, reduced to its top, bottom, left and right edge sums, position and frame-last flag.
    typedef struct packed {
        logic [9:0]  top_sum;
        logic [9:0]  bot_sum;
        logic [9:0]  left_sum;
        logic [9:0]  right_sum;
        logic [11:0] centre_row;
        logic [11:0] centre_col;
        logic        frame_last;
    } sums_t;

endpackage

// ----- hw/rtl/pem_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependencies.
module pem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/pem_front.sv -----
// Front part: pixel intake, raster counters, line store and 3x3 window.
// Depends on pem_pkg and pem_ram; pushes edge sums for interior pixels.
module pem_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      pixel,
    input  logic [12:0]                     frame_width,
    input  logic [12:0]                     frame_height,
    input  logic [pem_pkg::QUEUE_CW-1:0]    q_count,
    output logic                            push,
    output pem_pkg::sums_t                  entry
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = AW + 1;

    logic [AW-1:0] col_reg, col_next;
    logic [11:0]   row_reg, row_next;
    logic [CW-1:0] w_eff;
    logic [12:0]   h_eff;
    logic [CW-1:0] col_inc;
    logic [12:0]   row_inc;
    logic          accept;
    logic          interior;
    logic          last;

    logic          s0_valid_reg;
    logic          s0_interior_reg;
    logic          s0_last_reg;
    logic [7:0]    s0_pix_reg;
    logic [AW-1:0] s0_addr_reg;
    logic [11:0]   s0_row_reg;
    logic [11:0]   s0_col_reg;

    logic [7:0]    win_reg [6];
    logic [15:0]   ram_rd;
    logic [7:0]    pt, pm, pb;
    logic          pend;

    // Effective frame size, clamped to the supported range.
    always_comb
    begin
        priority if (32'(frame_width) >= MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else if (frame_width < pem_pkg::MIN_FRAME_SIZE)
            w_eff = CW'(3);
        else
            w_eff = CW'(frame_width);

        priority if (frame_height > pem_pkg::MAX_ROWS)
            h_eff = pem_pkg::MAX_ROWS;
        else if (frame_height < pem_pkg::MIN_FRAME_SIZE)
            h_eff = pem_pkg::MIN_FRAME_SIZE;
        else
            h_eff = frame_height;
    end

    assign pend     = s0_valid_reg & s0_interior_reg;
    assign in_ready = (4'(q_count) + 4'(pend)) < 4'(pem_pkg::QUEUE_DEPTH);
    assign accept   = in_valid & in_ready;

    assign col_inc  = {1'b0, col_reg} + CW'(1);
    assign row_inc  = {1'b0, row_reg} + 13'd1;
    assign interior = (row_reg >= 12'd2) && (col_reg >= AW'(2)) &&
                      ({1'b0, row_reg} < h_eff) && ({1'b0, col_reg} < w_eff);
    assign last     = (row_inc == h_eff) && (col_inc == w_eff);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? 12'd0 : row_inc[11:0];
        end
        else
        begin
            col_next = col_inc[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_pix_reg      <= pixel;
            s0_addr_reg     <= col_reg;
            s0_interior_reg <= interior;
            s0_last_reg     <= last;
            s0_row_reg      <= row_reg - 12'd1;
            s0_col_reg      <= 12'(col_reg - AW'(1));
        end
    end

    // The store entry is read when the pixel is taken and rewritten in the next
    // cycle, once the old middle row value is known.
    pem_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s0_valid_reg),
        .wr_addr (s0_addr_reg),
        .wr_data ({ram_rd[7:0], s0_pix_reg}),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (ram_rd)
    );

    assign pt = ram_rd[15:8];
    assign pm = ram_rd[7:0];
    assign pb = s0_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s0_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= pt;
            win_reg[4] <= pm;
            win_reg[5] <= pb;
        end
    end

    assign push = pend;

    always_comb
    begin
        entry.top_sum    = 10'(win_reg[0]) + 10'(win_reg[3]) + 10'(pt);
        entry.bot_sum    = 10'(win_reg[2]) + 10'(win_reg[5]) + 10'(pb);
        entry.left_sum   = 10'(win_reg[0]) + 10'(win_reg[1]) + 10'(win_reg[2]);
        entry.right_sum  = 10'(pt) + 10'(pm) + 10'(pb);
        entry.centre_row = s0_row_reg;
        entry.centre_col = s0_col_reg;
        entry.frame_last = s0_last_reg;
    end

    // An accepted pixel always reaches the window stage in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s0_valid_reg)
        else $error("accepted pixel did not reach the window stage");

endmodule

// ----- hw/rtl/pem_queue.sv -----
// Short queue of edge sums between the front and back parts.
// Depends on pem_pkg for the entry type and depth.
module pem_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  pem_pkg::sums_t               push_data,
    input  logic                         pop,
    output logic                         q_valid,
    output pem_pkg::sums_t               head,
    output logic [pem_pkg::QUEUE_CW-1:0] count
);

    pem_pkg::sums_t                   mem_reg [pem_pkg::QUEUE_DEPTH];
    logic [pem_pkg::QUEUE_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [pem_pkg::QUEUE_CW-1:0]     count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + pem_pkg::QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + pem_pkg::QUEUE_AW'(1);
            end
            count_reg <= count_reg + pem_pkg::QUEUE_CW'(push) - pem_pkg::QUEUE_CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign q_valid = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < pem_pkg::QUEUE_CW'(pem_pkg::QUEUE_DEPTH)) || pop)
        else $error("edge queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("edge queue underflow");

endmodule

// ----- hw/rtl/pem_back.sv -----
// Back part: absolute gradients, clamping and the output register.
// Depends on pem_pkg for the entry type and saturation constant.
module pem_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  pem_pkg::sums_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     edge_row_grad,
    output logic [7:0]     edge_col_grad,
    output logic [7:0]     edge_sum,
    output logic [11:0]    centre_row,
    output logic [11:0]    centre_col,
    output logic           frame_last
);

    logic       out_valid_reg;
    logic [7:0] row_grad_reg, col_grad_reg, sum_reg;
    logic [11:0] row_reg, col_reg;
    logic       last_reg;
    logic [9:0] d_row, d_col;
    logic [7:0] g_row, g_col;
    logic [8:0] g_sum;

    assign pop = q_valid & (~out_valid_reg | out_ready);

    always_comb
    begin
        d_row = (head.bot_sum >= head.top_sum) ? head.bot_sum - head.top_sum
                                               : head.top_sum - head.bot_sum;
        d_col = (head.right_sum >= head.left_sum) ? head.right_sum - head.left_sum
                                                  : head.left_sum - head.right_sum;
        g_row = (d_row[9:8] != 2'b00) ? pem_pkg::SAT_VALUE : d_row[7:0];
        g_col = (d_col[9:8] != 2'b00) ? pem_pkg::SAT_VALUE : d_col[7:0];
        g_sum = 9'(g_row) + 9'(g_col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            row_grad_reg <= g_row;
            col_grad_reg <= g_col;
            sum_reg      <= g_sum[8] ? pem_pkg::SAT_VALUE : g_sum[7:0];
            row_reg      <= head.centre_row;
            col_reg      <= head.centre_col;
            last_reg     <= head.frame_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign edge_row_grad = row_grad_reg;
    assign edge_col_grad = col_grad_reg;
    assign edge_sum      = sum_reg;
    assign centre_row    = row_reg;
    assign centre_col    = col_reg;
    assign frame_last    = last_reg;

    // A held result is never overwritten before the consumer takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !pop)
        else $error("output register overwritten while stalled");

endmodule

// ----- hw/rtl/prewitt_edge_magnitude.sv -----
// Top level of the streaming 3x3 Prewitt edge magnitude block.
// Depends on pem_pkg, pem_front, pem_queue and pem_back (pem_ram via pem_front).
//
// The block takes one 8-bit grayscale pixel per transaction in raster order
// and produces one result transaction for every interior pixel of the frame
// (border rows and columns give no result). Each result carries the absolute
// row gradient (bottom row sum minus top row sum), the absolute column gradient
// (right column sum minus left column sum), each clamped to 255, their sum
// saturated at 255, the row and column of the window centre, and frame_last on
// the final interior result of the frame. The block sustains one pixel per
// clock cycle while the queue has room: the only loop that limits it is the
// line store, a single dual-port RAM that is read when a pixel is taken and
// written back in the next cycle. Each pixel passes the line store read and
// stage-0 registers, the edge sums into the queue, then the gradients into
// the output register, and a four-entry queue lets input and output stall
// independently. Frame width and height are to be written through the
// configuration port only while the stream is idle; the block does not
// enforce this. Values below 3 act as 3, and values above MAX_WIDTH or 4096
// act as those limits. The line store needs no clearing after reset: every
// entry is written during the first two rows before it is used.
module prewitt_edge_magnitude #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  edge_row_grad,
    output logic [7:0]  edge_col_grad,
    output logic [7:0]  edge_sum,
    output logic [11:0] centre_row,
    output logic [11:0] centre_col,
    output logic        frame_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    logic [12:0]                      frame_width_reg;
    logic [12:0]                      frame_height_reg;
    logic                             push;
    logic                             pop;
    logic                             q_valid;
    pem_pkg::sums_t                   push_data;
    pem_pkg::sums_t                   head;
    logic [pem_pkg::QUEUE_CW-1:0]     q_count;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= pem_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= pem_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (pem_pkg::cfg_reg_t'(cfg_index))
                pem_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                pem_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:                   frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // Front part: counters, line store and window; produces the edge sums.
    pem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_count      (q_count),
        .push         (push),
        .entry        (push_data)
    );

    pem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_valid   (q_valid),
        .head      (head),
        .count     (q_count)
    );

    // Back part: gradients, clamping and the output register.
    pem_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .edge_row_grad (edge_row_grad),
        .edge_col_grad (edge_col_grad),
        .edge_sum      (edge_sum),
        .centre_row    (centre_row),
        .centre_col    (centre_col),
        .frame_last    (frame_last)
    );

    // The saturated sum is never below either of its gradients.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (edge_sum >= edge_row_grad) && (edge_sum >= edge_col_grad))
        else $error("edge sum below a gradient");

    // Interior centres never sit on row or column zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (centre_row != 12'd0) && (centre_col != 12'd0))
        else $error("result centred on the frame border");

endmodule
